/* rtl/core/assert_macros.svh */
// Assertion macros shared by the point to grid square RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication.
`define PGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

/* rtl/core/pgs_pkg.sv */
// Shared constants and types for the point to grid square block.
// Used by pgs_qtest, pgs_cell and point_to_grid_square_top; no dependencies.
package pgs_pkg;

  localparam int PIXEL_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 3;

  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TL_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TL_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TR_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TR_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BR_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BR_Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BL_X = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_BL_Y = 3'd7;

  localparam int NUM_LEVELS = 3;
  localparam int CELL_LAT   = 3;

  localparam logic [2:0] IDX_MAX = 3'd7;

  typedef struct packed {
    logic       valid;
    logic       in_grid;
    logic [2:0] col;
    logic [2:0] row;
  } ctl_t;

  typedef struct packed {
    logic boundary;
    logic odd;
    logic onseg;
  } qres_t;

endpackage

/* rtl/core/pgs_qtest.sv */
// Two-stage point-in-quadrilateral test with an on-segment check of edge q1-q2.
// Depends on pgs_pkg for the result type.
module pgs_qtest #(
  parameter int CW = pgs_pkg::PIXEL_BITS_DEF + pgs_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic [3:0][CW-1:0]    qx_i,
  input  logic [3:0][CW-1:0]    qy_i,
  input  logic [CW-1:0]         px_i,
  input  logic [CW-1:0]         py_i,
  output pgs_pkg::qres_t        res_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;

  logic [3:0]             skip_d, sbnd_d, neg_d;
  logic [3:0]             skip_q, sbnd_q, neg_q;
  logic signed [PW-1:0]   pa_d [4];
  logic signed [PW-1:0]   pb_d [4];
  logic signed [PW-1:0]   pa_q [4];
  logic signed [PW-1:0]   pb_q [4];
  logic [3:0]             bnd_e, cnt_e;

  logic signed [DW-1:0]   sdx, sdy, spx, spy;
  logic signed [PW-1:0]   oa_d, ob_d, oa_q, ob_q;
  logic                   rng_d, rng_q;
  pgs_pkg::qres_t         res_d, res_q;

  for (genvar i = 0; i < 4; i++) begin : g_edge
    localparam int WI = (i + 3) % 4;
    logic [CW-1:0]        wx, wy, vx, vy;
    logic signed [DW-1:0] dpy, dvx, dpx, dvy;
    logic signed [RW-1:0] delta;

    assign wx  = qx_i[WI];
    assign wy  = qy_i[WI];
    assign vx  = qx_i[i];
    assign vy  = qy_i[i];
    assign dpy = signed'({1'b0, py_i}) - signed'({1'b0, wy});
    assign dvx = signed'({1'b0, vx}) - signed'({1'b0, wx});
    assign dpx = signed'({1'b0, px_i}) - signed'({1'b0, wx});
    assign dvy = signed'({1'b0, vy}) - signed'({1'b0, wy});
    assign pa_d[i] = PW'(dpy) * PW'(dvx);
    assign pb_d[i] = PW'(dpx) * PW'(dvy);
    assign skip_d[i] = (wy <= py_i && vy <= py_i) || (wy > py_i && vy > py_i) ||
                       (wx < px_i && vx < px_i);
    assign sbnd_d[i] = (py_i == vy) && ((px_i == vx) || ((py_i == wy) &&
                       ((wx <= px_i && px_i <= vx) || (vx <= px_i && px_i <= wx))));
    assign neg_d[i] = vy < wy;

    assign delta    = RW'(pa_q[i]) - RW'(pb_q[i]);
    assign bnd_e[i] = skip_q[i] ? sbnd_q[i] : (delta == '0);
    assign cnt_e[i] = !skip_q[i] && (neg_q[i] ? (delta < 0) : (delta > 0));
  end

  // The on-segment check always looks at the edge from q1 to q2.
  assign sdx  = signed'({1'b0, qx_i[2]}) - signed'({1'b0, qx_i[1]});
  assign sdy  = signed'({1'b0, qy_i[2]}) - signed'({1'b0, qy_i[1]});
  assign spx  = signed'({1'b0, px_i}) - signed'({1'b0, qx_i[1]});
  assign spy  = signed'({1'b0, py_i}) - signed'({1'b0, qy_i[1]});
  assign oa_d = PW'(sdx) * PW'(spy);
  assign ob_d = PW'(sdy) * PW'(spx);
  assign rng_d = !((px_i < qx_i[1] && px_i < qx_i[2]) || (px_i > qx_i[1] && px_i > qx_i[2]) ||
                   (py_i < qy_i[1] && py_i < qy_i[2]) || (py_i > qy_i[1] && py_i > qy_i[2]));

  always_comb begin
    res_d.boundary = |bnd_e;
    res_d.odd      = ^cnt_e;
    res_d.onseg    = rng_q && (oa_q == ob_q);
  end

  always_ff @(posedge clk_i) begin
    skip_q <= skip_d;
    sbnd_q <= sbnd_d;
    neg_q  <= neg_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    oa_q   <= oa_d;
    ob_q   <= ob_d;
    rng_q  <= rng_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/pgs_cell.sv */
// One search level: picks the inner lines for column and row, tests both
// regions and hands the refined indexes to the next cell. Uses pgs_pkg, pgs_qtest.
module pgs_cell #(
  parameter int LEVEL         = 0,
  parameter int PIXEL_BITS    = pgs_pkg::PIXEL_BITS_DEF,
  parameter int FRACTION_BITS = pgs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [pgs_pkg::NUM_REGS-1:0][PIXEL_BITS-1:0]  corners_i,
  input  pgs_pkg::ctl_t                                 ctl_i,
  input  logic [PIXEL_BITS+FRACTION_BITS-1:0]           px_i,
  input  logic [PIXEL_BITS+FRACTION_BITS-1:0]           py_i,
  output pgs_pkg::ctl_t                                 ctl_o,
  output logic [PIXEL_BITS+FRACTION_BITS-1:0]           px_o,
  output logic [PIXEL_BITS+FRACTION_BITS-1:0]           py_o
);

  localparam int         CW   = PIXEL_BITS + FRACTION_BITS;
  localparam int         PB   = PIXEL_BITS;
  localparam int         BIT  = 2 - LEVEL;
  localparam logic [2:0] TAIL = 3'((1 << BIT) - 1);

  function automatic logic [CW-1:0] edge_pt(input logic [PB-1:0] a,
                                            input logic [PB-1:0] c,
                                            input logic [2:0]    k);
    logic [2:0]           kp1;
    logic signed [PB+5:0] av, cv, acc;
    kp1 = k + 3'd1;
    av  = signed'({6'b000000, a});
    cv  = signed'({6'b000000, c});
    acc = (av <<< 3) + signed'({{(PB+3){1'b0}}, kp1}) * (cv - av);
    edge_pt = CW'(acc[PB+2:0]) << (FRACTION_BITS - 3);
  endfunction

  function automatic logic [CW-1:0] fix(input logic [PB-1:0] a);
    fix = CW'(a) << FRACTION_BITS;
  endfunction

  logic [2:0]          kc, kr;
  logic [PB-1:0]       tlx, tly, trx, try_, brx, bry, blx, bly;
  logic [3:0][CW-1:0]  cqx_d, cqy_d, rqx_d, rqy_d;
  logic [3:0][CW-1:0]  cqx_q, cqy_q, rqx_q, rqy_q;
  logic [CW-1:0]       px_s0_q, py_s0_q, px_s1_q, py_s1_q, px_s2_q, py_s2_q;
  pgs_pkg::ctl_t       ctl_s0_q, ctl_s1_q, ctl_s2_q;
  pgs_pkg::qres_t      cres, rres;
  logic                before_c, before_r;

  assign tlx  = corners_i[pgs_pkg::REG_TL_X];
  assign tly  = corners_i[pgs_pkg::REG_TL_Y];
  assign trx  = corners_i[pgs_pkg::REG_TR_X];
  assign try_ = corners_i[pgs_pkg::REG_TR_Y];
  assign brx  = corners_i[pgs_pkg::REG_BR_X];
  assign bry  = corners_i[pgs_pkg::REG_BR_Y];
  assign blx  = corners_i[pgs_pkg::REG_BL_X];
  assign bly  = corners_i[pgs_pkg::REG_BL_Y];

  // Known upper index bits, then a zero and trailing ones, name the line.
  assign kc = ctl_i.col | TAIL;
  assign kr = ctl_i.row | TAIL;

  always_comb begin
    cqx_d[0] = fix(tlx);
    cqy_d[0] = fix(tly);
    cqx_d[1] = edge_pt(tlx, trx, kc);
    cqy_d[1] = edge_pt(tly, try_, kc);
    cqx_d[2] = edge_pt(blx, brx, kc);
    cqy_d[2] = edge_pt(bly, bry, kc);
    cqx_d[3] = fix(blx);
    cqy_d[3] = fix(bly);
    rqx_d[0] = fix(tlx);
    rqy_d[0] = fix(tly);
    rqx_d[1] = edge_pt(tlx, blx, kr);
    rqy_d[1] = edge_pt(tly, bly, kr);
    rqx_d[2] = edge_pt(trx, brx, kr);
    rqy_d[2] = edge_pt(try_, bry, kr);
    rqx_d[3] = fix(trx);
    rqy_d[3] = fix(try_);
  end

  always_ff @(posedge clk_i) begin
    cqx_q   <= cqx_d;
    cqy_q   <= cqy_d;
    rqx_q   <= rqx_d;
    rqy_q   <= rqy_d;
    px_s0_q <= px_i;
    py_s0_q <= py_i;
    px_s1_q <= px_s0_q;
    py_s1_q <= py_s0_q;
    px_s2_q <= px_s1_q;
    py_s2_q <= py_s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s0_q <= '0;
      ctl_s1_q <= '0;
      ctl_s2_q <= '0;
    end else begin
      ctl_s0_q <= ctl_i;
      ctl_s1_q <= ctl_s0_q;
      ctl_s2_q <= ctl_s1_q;
    end
  end

  pgs_qtest #(.CW(CW)) u_col_test (
    .clk_i (clk_i),
    .qx_i  (cqx_q),
    .qy_i  (cqy_q),
    .px_i  (px_s0_q),
    .py_i  (py_s0_q),
    .res_o (cres)
  );

  pgs_qtest #(.CW(CW)) u_row_test (
    .clk_i (clk_i),
    .qx_i  (rqx_q),
    .qy_i  (rqy_q),
    .px_i  (px_s0_q),
    .py_i  (py_s0_q),
    .res_o (rres)
  );

  // A point on the region outline counts as before the line unless it lies on the line.
  assign before_c = cres.boundary ? !cres.onseg : cres.odd;
  assign before_r = rres.boundary ? !rres.onseg : rres.odd;

  always_comb begin
    ctl_o          = ctl_s2_q;
    ctl_o.col[BIT] = !before_c;
    ctl_o.row[BIT] = !before_r;
  end

  assign px_o = px_s2_q;
  assign py_o = py_s2_q;

endmodule

/* rtl/core/point_to_grid_square_top.sv */
// Top level of the point to grid square block: configuration registers,
// outline test and the chain of search cells. Uses pgs_pkg, pgs_qtest, pgs_cell.

// A point is taken in every clock cycle in which start is high; busy never rises.
// Its result appears on the output ports for one cycle, marked by valid_o. The
// receiver cannot stall the block, so it must capture each result in that cycle.
// A request passes through three search cells of three register stages each
// (line selection, cross products, decision) and one output register; the outline
// test runs alongside the first cell. Corner registers take effect for requests
// taken in the cycle after the write.
`include "assert_macros.svh"

module point_to_grid_square_top #(
  parameter int PIXEL_BITS    = pgs_pkg::PIXEL_BITS_DEF,
  parameter int FRACTION_BITS = pgs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pgs_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [PIXEL_BITS-1:0]                cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PIXEL_BITS+FRACTION_BITS-1:0]  point_x_i,
  input  logic [PIXEL_BITS+FRACTION_BITS-1:0]  point_y_i,
  output logic                                 valid_o,
  output logic                                 inside_res_o,
  output logic [2:0]                           local_column_o,
  output logic [2:0]                           local_row_o,
  output logic [2:0]                           board_x_o,
  output logic [2:0]                           board_y_o
);

  localparam int CW  = PIXEL_BITS + FRACTION_BITS;
  localparam int NL  = pgs_pkg::NUM_LEVELS;
  localparam int LAT = pgs_pkg::NUM_LEVELS * pgs_pkg::CELL_LAT + 1;

  logic [pgs_pkg::NUM_REGS-1:0][PIXEL_BITS-1:0] corners_q;
  logic [3:0][CW-1:0]  ox, oy;
  logic [CW-1:0]       pxo_q, pyo_q;
  pgs_pkg::qres_t      ores;
  logic                accept;

  pgs_pkg::ctl_t       ctl_in  [NL];
  pgs_pkg::ctl_t       ctl_out [NL];
  logic [CW-1:0]       px_in   [NL];
  logic [CW-1:0]       py_in   [NL];
  logic [CW-1:0]       px_out  [NL];
  logic [CW-1:0]       py_out  [NL];
  pgs_pkg::ctl_t       last;

  logic                valid_q;
  logic                in_grid_q;
  logic [2:0]          col_q, row_q, bx_q, by_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q <= '0;
    end else if (cfg_we_i) begin
      corners_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Outline test, aligned with the first search cell.
  always_comb begin
    ox[0] = CW'(corners_q[pgs_pkg::REG_TL_X]) << FRACTION_BITS;
    oy[0] = CW'(corners_q[pgs_pkg::REG_TL_Y]) << FRACTION_BITS;
    ox[1] = CW'(corners_q[pgs_pkg::REG_TR_X]) << FRACTION_BITS;
    oy[1] = CW'(corners_q[pgs_pkg::REG_TR_Y]) << FRACTION_BITS;
    ox[2] = CW'(corners_q[pgs_pkg::REG_BR_X]) << FRACTION_BITS;
    oy[2] = CW'(corners_q[pgs_pkg::REG_BR_Y]) << FRACTION_BITS;
    ox[3] = CW'(corners_q[pgs_pkg::REG_BL_X]) << FRACTION_BITS;
    oy[3] = CW'(corners_q[pgs_pkg::REG_BL_Y]) << FRACTION_BITS;
  end

  always_ff @(posedge clk_i) begin
    pxo_q <= point_x_i;
    pyo_q <= point_y_i;
  end

  pgs_qtest #(.CW(CW)) u_outline (
    .clk_i (clk_i),
    .qx_i  (ox),
    .qy_i  (oy),
    .px_i  (pxo_q),
    .py_i  (pyo_q),
    .res_o (ores)
  );

  for (genvar g = 0; g < NL; g++) begin : g_chain
    if (g == 0) begin : g_head
      always_comb begin
        ctl_in[g]        = '0;
        ctl_in[g].valid  = accept;
        px_in[g]         = point_x_i;
        py_in[g]         = point_y_i;
      end
    end else if (g == 1) begin : g_join
      always_comb begin
        ctl_in[g]         = ctl_out[g-1];
        ctl_in[g].in_grid = ores.boundary || ores.odd;
        px_in[g]          = px_out[g-1];
        py_in[g]          = py_out[g-1];
      end
    end else begin : g_link
      always_comb begin
        ctl_in[g] = ctl_out[g-1];
        px_in[g]  = px_out[g-1];
        py_in[g]  = py_out[g-1];
      end
    end

    pgs_cell #(
      .LEVEL         (g),
      .PIXEL_BITS    (PIXEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .corners_i (corners_q),
      .ctl_i     (ctl_in[g]),
      .px_i      (px_in[g]),
      .py_i      (py_in[g]),
      .ctl_o     (ctl_out[g]),
      .px_o      (px_out[g]),
      .py_o      (py_out[g])
    );
  end

  assign last = ctl_out[NL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    in_grid_q <= last.in_grid;
    col_q     <= last.in_grid ? last.col : 3'd0;
    row_q     <= last.in_grid ? last.row : 3'd0;
    bx_q      <= last.in_grid ? pgs_pkg::IDX_MAX - last.row : 3'd0;
    by_q      <= last.in_grid ? pgs_pkg::IDX_MAX - last.col : 3'd0;
  end

  assign valid_o        = valid_q;
  assign inside_res_o   = in_grid_q;
  assign local_column_o = col_q;
  assign local_row_o    = row_q;
  assign board_x_o      = bx_q;
  assign board_y_o      = by_q;

  `PGS_ASSERT_IMP(a_latency, accept, ##LAT valid_o, "request not answered on time")
  `PGS_ASSERT_IMP(a_no_spurious, valid_o, $past(accept, LAT), "result without a request")
  `PGS_ASSERT_IMP(a_outside_zero, valid_o && !inside_res_o, local_column_o == 3'd0 && local_row_o == 3'd0 && board_x_o == 3'd0 && board_y_o == 3'd0, "outside result not cleared")
  `PGS_ASSERT_NXT(a_chain_out, last.valid, valid_o, "last cell result not presented")

endmodule

/* tb/square_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the point to grid square block: its own grid model, a copy of
// the corner registers and the queue of expected squares. Depends on pgs_pkg.
package square_scoreboard_pkg;
  import pgs_pkg::*;

  localparam int PIX_W = PIXEL_BITS_DEF;
  localparam int PT_W = PIXEL_BITS_DEF + FRACTION_BITS_DEF;
  localparam longint SUB_EIGHTH = longint'(1) << (FRACTION_BITS_DEF - 3);

  typedef enum int {
    REGION_OUT  = -1,
    REGION_EDGE = 0,
    REGION_IN   = 1
  } region_e;

  typedef struct {
    longint x;
    longint y;
  } gpoint_t;

  typedef struct packed {
    logic       in_grid;
    logic [2:0] col;
    logic [2:0] row;
    logic [2:0] bx;
    logic [2:0] by;
  } square_t;

  class square_scoreboard;
    bit [PIX_W-1:0] corner_reg [NUM_REGS];
    square_t expected_squares [$];
    int errors;
    int reported;

    function new();
      foreach (corner_reg[i]) corner_reg[i] = '0;
      errors = 0;
      reported = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PIX_W-1:0] val);
      corner_reg[idx] = val;
    endfunction

    function int pending();
      return expected_squares.size();
    endfunction

    function gpoint_t corner_at(logic [CFG_IDX_BITS-1:0] ix, logic [CFG_IDX_BITS-1:0] iy);
      gpoint_t c;
      c.x = longint'(corner_reg[ix]) * 8 * SUB_EIGHTH;
      c.y = longint'(corner_reg[iy]) * 8 * SUB_EIGHTH;
      return c;
    endfunction

    // Inner line end point k on the edge from corner s to corner e.
    function gpoint_t split_point(logic [CFG_IDX_BITS-1:0] sx, logic [CFG_IDX_BITS-1:0] sy,
                                  logic [CFG_IDX_BITS-1:0] ex, logic [CFG_IDX_BITS-1:0] ey,
                                  int k);
      longint a, b, c, d;
      gpoint_t q;
      a = longint'(corner_reg[sx]);
      b = longint'(corner_reg[sy]);
      c = longint'(corner_reg[ex]);
      d = longint'(corner_reg[ey]);
      q.x = (a * 8 + longint'(k + 1) * (c - a)) * SUB_EIGHTH;
      q.y = (b * 8 + longint'(k + 1) * (d - b)) * SUB_EIGHTH;
      return q;
    endfunction

    function region_e quad_region(gpoint_t q [4], gpoint_t p);
      int count;
      gpoint_t v, w;
      longint delta;
      count = 0;
      v = q[3];
      for (int i = 0; i < 4; i++) begin
        w = v;
        v = q[i];
        if ((w.y <= p.y && v.y <= p.y) || (w.y > p.y && v.y > p.y) ||
            (w.x < p.x && v.x < p.x)) begin
          if (p.y == v.y && (p.x == v.x || (p.y == w.y &&
              ((w.x <= p.x && p.x <= v.x) || (v.x <= p.x && p.x <= w.x)))))
            return REGION_EDGE;
          continue;
        end
        delta = (p.y - w.y) * (v.x - w.x) - (p.x - w.x) * (v.y - w.y);
        if (delta == 0) return REGION_EDGE;
        if (v.y < w.y) delta = -delta;
        if (delta > 0) count++;
      end
      return count[0] ? REGION_IN : REGION_OUT;
    endfunction

    function bit on_segment(gpoint_t p, gpoint_t a, gpoint_t b);
      longint cr;
      cr = (b.x - a.x) * (p.y - a.y) - (b.y - a.y) * (p.x - a.x);
      if (cr != 0) return 1'b0;
      if (p.x < ((a.x < b.x) ? a.x : b.x) || p.x > ((a.x > b.x) ? a.x : b.x)) return 1'b0;
      if (p.y < ((a.y < b.y) ? a.y : b.y) || p.y > ((a.y > b.y) ? a.y : b.y)) return 1'b0;
      return 1'b1;
    endfunction

    // A point on the region boundary but not on the inner line itself counts as before it.
    function bit before_line(gpoint_t p, gpoint_t s0, gpoint_t s1, gpoint_t a, gpoint_t b);
      gpoint_t quad [4];
      region_e t;
      quad[0] = s0;
      quad[1] = a;
      quad[2] = b;
      quad[3] = s1;
      t = quad_region(quad, p);
      if (t == REGION_IN) return 1'b1;
      if (t == REGION_EDGE && !on_segment(p, a, b)) return 1'b1;
      return 1'b0;
    endfunction

    function int search_index(gpoint_t p, gpoint_t s0, gpoint_t s1,
                              gpoint_t l0 [7], gpoint_t l1 [7]);
      if (before_line(p, s0, s1, l0[3], l1[3])) begin
        if (before_line(p, s0, s1, l0[1], l1[1]))
          return before_line(p, s0, s1, l0[0], l1[0]) ? 0 : 1;
        return before_line(p, s0, s1, l0[2], l1[2]) ? 2 : 3;
      end
      if (before_line(p, s0, s1, l0[5], l1[5]))
        return before_line(p, s0, s1, l0[4], l1[4]) ? 4 : 5;
      return before_line(p, s0, s1, l0[6], l1[6]) ? 6 : 7;
    endfunction

    function square_t locate_square(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
      gpoint_t p, tl, tr, br, bl;
      gpoint_t outline [4];
      gpoint_t top_pts [7];
      gpoint_t bot_pts [7];
      gpoint_t left_pts [7];
      gpoint_t right_pts [7];
      square_t sq;
      int col, row;
      p.x = longint'(px);
      p.y = longint'(py);
      tl = corner_at(REG_TL_X, REG_TL_Y);
      tr = corner_at(REG_TR_X, REG_TR_Y);
      br = corner_at(REG_BR_X, REG_BR_Y);
      bl = corner_at(REG_BL_X, REG_BL_Y);
      outline[0] = tl;
      outline[1] = tr;
      outline[2] = br;
      outline[3] = bl;
      sq = '0;
      if (quad_region(outline, p) == REGION_OUT) return sq;
      for (int k = 0; k < 7; k++) begin
        top_pts[k] = split_point(REG_TL_X, REG_TL_Y, REG_TR_X, REG_TR_Y, k);
        bot_pts[k] = split_point(REG_BL_X, REG_BL_Y, REG_BR_X, REG_BR_Y, k);
        left_pts[k] = split_point(REG_TL_X, REG_TL_Y, REG_BL_X, REG_BL_Y, k);
        right_pts[k] = split_point(REG_TR_X, REG_TR_Y, REG_BR_X, REG_BR_Y, k);
      end
      col = search_index(p, tl, bl, top_pts, bot_pts);
      row = search_index(p, tl, tr, left_pts, right_pts);
      sq.in_grid = 1'b1;
      sq.col = 3'(col);
      sq.row = 3'(row);
      sq.bx = IDX_MAX - sq.row;
      sq.by = IDX_MAX - sq.col;
      return sq;
    endfunction

    function void note_request(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
      expected_squares = {expected_squares, locate_square(px, py)};
    endfunction

    function void check_result(square_t got);
      square_t want;
      if (expected_squares.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected result: inside=%0d col=%0d row=%0d bx=%0d by=%0d",
                   got.in_grid, got.col, got.row, got.bx, got.by);
        reported++;
        return;
      end
      want = expected_squares.pop_front();
      if (got !== want) begin
        errors++;
        if (reported < 10)
          $display({"mismatch: expected inside=%0d col=%0d row=%0d bx=%0d by=%0d, ",
                    "got inside=%0d col=%0d row=%0d bx=%0d by=%0d"},
                   want.in_grid, want.col, want.row, want.bx, want.by,
                   got.in_grid, got.col, got.row, got.bx, got.by);
        reported++;
      end
    endfunction
  endclass

endpackage

/* tb/point_to_grid_square_top_test.sv */
`timescale 1ns / 100ps
// Top of the point to grid square testbench: clock, reset, stimulus and result
// monitor. Depends on pgs_pkg, square_scoreboard_pkg and point_to_grid_square_top.
module point_to_grid_square_top_test;
  import pgs_pkg::*;
  import square_scoreboard_pkg::*;

  localparam int ONE_PIXEL = 1 << FRACTION_BITS_DEF;
  localparam int PT_MAX = (1 << PT_W) - 1;
  localparam logic [CFG_IDX_BITS-1:0] X_REGS [4] = '{REG_TL_X, REG_TR_X, REG_BR_X, REG_BL_X};
  localparam logic [CFG_IDX_BITS-1:0] Y_REGS [4] = '{REG_TL_Y, REG_TR_Y, REG_BR_Y, REG_BL_Y};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [PIX_W-1:0]        cfg_wdata_i;
  logic                    start;
  logic                    busy;
  logic [PT_W-1:0]         point_x_i;
  logic [PT_W-1:0]         point_y_i;
  logic                    valid_o;
  logic                    inside_res_o;
  logic [2:0]              local_column_o;
  logic [2:0]              local_row_o;
  logic [2:0]              board_x_o;
  logic [2:0]              board_y_o;

  square_scoreboard sb = new();
  int corner_val [NUM_REGS];
  int idle_pct;

  point_to_grid_square_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .valid_o        (valid_o),
    .inside_res_o   (inside_res_o),
    .local_column_o (local_column_o),
    .local_row_o    (local_row_o),
    .board_x_o      (board_x_o),
    .board_y_o      (board_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3600000;
    $display("FAIL point_to_grid_square_top");
    $finish;
  end

  always @(posedge clk_i) begin
    square_t got;
    if (rst_ni) begin
      if (valid_o) begin
        got.in_grid = inside_res_o;
        got.col = local_column_o;
        got.row = local_row_o;
        got.bx = board_x_o;
        got.by = board_y_o;
        sb.check_result(got);
      end
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (start && !busy) sb.note_request(point_x_i, point_y_i);
    end
  end

  task automatic send_point(input int px, input int py);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    point_x_i <= PT_W'(px);
    point_y_i <= PT_W'(py);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_grid(input int tl_x, input int tl_y, input int tr_x, input int tr_y,
                            input int br_x, input int br_y, input int bl_x, input int bl_y);
    drain();
    corner_val[REG_TL_X] = tl_x;
    corner_val[REG_TL_Y] = tl_y;
    corner_val[REG_TR_X] = tr_x;
    corner_val[REG_TR_Y] = tr_y;
    corner_val[REG_BR_X] = br_x;
    corner_val[REG_BR_Y] = br_y;
    corner_val[REG_BL_X] = bl_x;
    corner_val[REG_BL_Y] = bl_y;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_BITS'(i);
      cfg_wdata_i <= PIX_W'(corner_val[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Most points fall in the bounding box of the grid or on its inner lines.
  task automatic run_random(input int count);
    int lo_x, hi_x, lo_y, hi_y, x, y, sel, k, m, v;
    int ax, ay, bx, by;
    lo_x = PT_MAX;
    lo_y = PT_MAX;
    hi_x = 0;
    hi_y = 0;
    for (int i = 0; i < 4; i++) begin
      if (corner_val[X_REGS[i]] * ONE_PIXEL < lo_x) lo_x = corner_val[X_REGS[i]] * ONE_PIXEL;
      if (corner_val[X_REGS[i]] * ONE_PIXEL > hi_x) hi_x = corner_val[X_REGS[i]] * ONE_PIXEL;
      if (corner_val[Y_REGS[i]] * ONE_PIXEL < lo_y) lo_y = corner_val[Y_REGS[i]] * ONE_PIXEL;
      if (corner_val[Y_REGS[i]] * ONE_PIXEL > hi_y) hi_y = corner_val[Y_REGS[i]] * ONE_PIXEL;
    end
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        x = $urandom_range(hi_x, lo_x);
        y = $urandom_range(hi_y, lo_y);
      end else if (sel < 75) begin
        k = $urandom_range(6);
        if ($urandom_range(1) == 0) begin
          ax = corner_val[REG_TL_X] * 8 + (k + 1) * (corner_val[REG_TR_X] - corner_val[REG_TL_X]);
          ay = corner_val[REG_TL_Y] * 8 + (k + 1) * (corner_val[REG_TR_Y] - corner_val[REG_TL_Y]);
          bx = corner_val[REG_BL_X] * 8 + (k + 1) * (corner_val[REG_BR_X] - corner_val[REG_BL_X]);
          by = corner_val[REG_BL_Y] * 8 + (k + 1) * (corner_val[REG_BR_Y] - corner_val[REG_BL_Y]);
        end else begin
          ax = corner_val[REG_TL_X] * 8 + (k + 1) * (corner_val[REG_BL_X] - corner_val[REG_TL_X]);
          ay = corner_val[REG_TL_Y] * 8 + (k + 1) * (corner_val[REG_BL_Y] - corner_val[REG_TL_Y]);
          bx = corner_val[REG_TR_X] * 8 + (k + 1) * (corner_val[REG_BR_X] - corner_val[REG_TR_X]);
          by = corner_val[REG_TR_Y] * 8 + (k + 1) * (corner_val[REG_BR_Y] - corner_val[REG_TR_Y]);
        end
        m = $urandom_range(8);
        x = (ax + ((bx - ax) * m) / 8) * int'(SUB_EIGHTH);
        y = (ay + ((by - ay) * m) / 8) * int'(SUB_EIGHTH);
      end else if (sel < 88) begin
        v = $urandom_range(3);
        x = corner_val[X_REGS[v]] * ONE_PIXEL + int'($urandom_range(6)) - 3;
        y = corner_val[Y_REGS[v]] * ONE_PIXEL + int'($urandom_range(6)) - 3;
      end else begin
        x = $urandom_range(PT_MAX);
        y = $urandom_range(PT_MAX);
      end
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x > PT_MAX) x = PT_MAX;
      if (y > PT_MAX) y = PT_MAX;
      send_point(x, y);
    end
  endtask

  initial begin
    int kind, bx0, by0, w;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    start <= 1'b0;
    point_x_i <= '0;
    point_y_i <= '0;
    foreach (corner_val[i]) corner_val[i] = 0;
    idle_pct = 20;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All corners at the origin after reset.
    send_point(0, 0);
    send_point(8, 0);
    send_point(PT_MAX, PT_MAX);

    // Axis aligned square: vertices, edges, inner lines and just outside.
    apply_grid(100, 100, 900, 100, 900, 900, 100, 900);
    send_point(800, 800);
    send_point(7200, 7200);
    send_point(4000, 4000);
    send_point(4000, 800);
    send_point(799, 4000);
    send_point(7201, 4000);
    send_point(1600, 1600);
    send_point(1599, 1599);
    send_point(PT_MAX, 0);
    send_point(0, PT_MAX);

    // Grid over the whole pixel range.
    apply_grid(0, 0, 4095, 0, 4095, 4095, 0, 4095);
    send_point(0, 0);
    send_point(32760, 32760);
    send_point(PT_MAX, PT_MAX);
    send_point(16380, 16380);
    send_point(32760, 0);
    send_point(1, 32759);

    // Self-crossing outline.
    apply_grid(0, 0, 4095, 4095, 4095, 0, 0, 4095);
    send_point(16380, 16380);
    send_point(100, 16380);
    send_point(16380, 100);

    for (int c = 0; c < 9; c++) begin
      idle_pct = (c < 3) ? 20 : ((c < 6) ? 80 : 0);
      kind = $urandom_range(3);
      if (kind == 2) begin
        bx0 = $urandom_range(4000);
        by0 = $urandom_range(4000);
        w = $urandom_range(40, 8);
        apply_grid(bx0, by0, bx0 + w, by0 + int'($urandom_range(3)),
                   bx0 + w + int'($urandom_range(3)), by0 + w, bx0, by0 + w);
      end else if (kind == 3) begin
        apply_grid($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095));
      end else begin
        apply_grid($urandom_range(1500), $urandom_range(1500),
                   $urandom_range(4095, 2500), $urandom_range(1500),
                   $urandom_range(4095, 2500), $urandom_range(4095, 2500),
                   $urandom_range(1500), $urandom_range(4095, 2500));
      end
      run_random(100);
    end

    drain();
    repeat (NUM_LEVELS * CELL_LAT + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS point_to_grid_square_top");
    end else begin
      $display("FAIL point_to_grid_square_top");
    end
    $finish;
  end

endmodule

/* point_to_grid_square_top.f */
+incdir+rtl/core
rtl/core/pgs_pkg.sv
rtl/core/pgs_qtest.sv
rtl/core/pgs_cell.sv
rtl/core/point_to_grid_square_top.sv
tb/square_scoreboard_pkg.sv
tb/point_to_grid_square_top_test.sv
